@@ rtl/core/assert_macros.svh @@
// assertion helper macros for the minimum window search core
// empty bodies when SYNTHESIS is defined; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MWCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("mwcs assertion failed");
`define MWCS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("mwcs forbidden condition");
`else
`define MWCS_ASSERT(lbl, clk, rstn, prop)
`define MWCS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/core/mwcs_pkg.sv @@
// shared types and constants of the minimum window search core
// no dependencies
`timescale 1ns / 1ps
package mwcs_pkg;
  localparam int CMD_W        = 2;
  localparam int SYM_IN_W     = 8;
  localparam int WIN_START_W  = 12;
  localparam int WIN_LENGTH_W = 13;
  localparam int OUTST_W      = 13;
  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [OUTST_W-1:0] OUTSTANDING_MAX = 13'd8191;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SYM_IN_W-1:0] sym;
    logic                in_alpha;
    logic                last;
  } op_t;
endpackage

@@ rtl/core/mwcs_if.sv @@
// valid/ready channel interfaces for the input and result beats
// depends on mwcs_pkg
`timescale 1ns / 1ps
interface mwcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [mwcs_pkg::CMD_W-1:0]    cmd;
  logic [mwcs_pkg::SYM_IN_W-1:0] symbol;
  logic                          last;
  modport source (output valid, output cmd, output symbol, output last, input ready);
  modport sink (input valid, input cmd, input symbol, input last, output ready);
endinterface

interface mwcs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [mwcs_pkg::WIN_START_W-1:0]  win_start;
  logic [mwcs_pkg::WIN_LENGTH_W-1:0] win_length;
  logic                              overflow;
  modport source (output valid, output found, output win_start, output win_length,
                  output overflow, input ready);
  modport sink (input valid, input found, input win_start, input win_length,
                input overflow, output ready);
endinterface

@@ rtl/core/mwcs_front.sv @@
// front end: accepts input beats, classifies them, and queues operations
// depends on mwcs_pkg and mwcs_if
`timescale 1ns / 1ps
module mwcs_front #(
  parameter int ALPHABET = mwcs_pkg::ALPHABET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  mwcs_in_if.sink        in_bus,
  output logic           op_valid,
  output mwcs_pkg::op_t  op,
  input  logic           op_pop
);
  localparam int CNT_W = $clog2(mwcs_pkg::QUEUE_DEPTH + 1);

  mwcs_pkg::op_t q_r [mwcs_pkg::QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic             wr_r;
  logic             rd_r;
  logic             accept;
  logic             keep;
  logic             push;
  logic             in_alpha;
  mwcs_pkg::op_t    new_op;

  assign in_bus.ready = (cnt_r != CNT_W'(mwcs_pkg::QUEUE_DEPTH));
  assign accept       = in_bus.valid && in_bus.ready;
  assign in_alpha     = ({1'b0, in_bus.symbol} < 9'(ALPHABET));

  // unused commands and out-of-alphabet pattern bytes are dropped here
  always_comb begin
    new_op.sym      = in_bus.symbol;
    new_op.in_alpha = in_alpha;
    new_op.last     = 1'b0;
    new_op.kind     = mwcs_pkg::OP_CLEAR;
    keep            = 1'b0;
    case (in_bus.cmd)
      mwcs_pkg::CMD_CLEAR: begin
        keep = 1'b1;
      end
      mwcs_pkg::CMD_PATTERN: begin
        new_op.kind = mwcs_pkg::OP_PATTERN;
        keep        = in_alpha;
      end
      mwcs_pkg::CMD_TEXT: begin
        new_op.kind = mwcs_pkg::OP_TEXT;
        new_op.last = in_bus.last;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push     = accept && keep;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= new_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (op_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(op_pop);
    end
  end
endmodule

@@ rtl/core/mwcs_back.sv @@
// back end: sequencer over the need table and position fifo, result register
// depends on mwcs_pkg, mwcs_if and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mwcs_back #(
  parameter int MAX_LEN  = mwcs_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = mwcs_pkg::ALPHABET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  mwcs_pkg::op_t  op,
  output logic           op_pop,
  mwcs_out_if.source     out_bus
);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int SYM_W  = $clog2(ALPHABET);
  localparam int NEED_W = ((LEN_W > 13) ? LEN_W : 13) + 1;
  localparam int OW     = mwcs_pkg::OUTST_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAT   = 3'd1;
  localparam logic [2:0] ST_TXT   = 3'd2;
  localparam logic [2:0] ST_SH    = 3'd3;
  localparam logic [2:0] ST_SH_LD = 3'd4;
  localparam logic [2:0] ST_SH_WR = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic signed [NEED_W-1:0] need_mem [ALPHABET];
  logic signed [NEED_W-1:0] need_q_r;
  logic                     need_vq_r;
  logic [ALPHABET-1:0]      need_vld_r;
  logic [ALPHABET-1:0]      member_r;
  logic [SYM_W+ADDR_W-1:0]  fifo_mem [MAX_LEN];
  logic [SYM_W+ADDR_W-1:0]  fifo_q_r;

  logic [OW-1:0]     outst_r, outst_nxt;
  logic [LEN_W-1:0]  head_r, head_nxt;
  logic [LEN_W-1:0]  tail_r, tail_nxt;
  logic [LEN_W-1:0]  tpos_r, tpos_nxt;
  logic [ADDR_W-1:0] cur_pos_r, cur_pos_nxt;
  logic [SYM_W-1:0]  cur_sym_r, cur_sym_nxt;
  logic              cur_last_r, cur_last_nxt;
  logic [ADDR_W-1:0] best_start_r, best_start_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              clr;
  logic              member_set;

  logic                     need_re, need_we;
  logic [SYM_W-1:0]         need_raddr, need_waddr;
  logic signed [NEED_W-1:0] need_wdata;
  logic signed [NEED_W-1:0] nd;
  logic                     fifo_we, fifo_re;

  logic                     out_valid_r;
  logic                     out_found_r;
  logic [mwcs_pkg::WIN_START_W-1:0]  out_start_r;
  logic [mwcs_pkg::WIN_LENGTH_W-1:0] out_len_r;
  logic                     out_ovf_r;
  logic                     res_load;

  logic [SYM_W-1:0]  f_sym;
  logic [ADDR_W-1:0] f_pos;
  logic [LEN_W-1:0]  win_len;
  logic [SYM_W-1:0]  op_sym;

  assign nd      = need_vq_r ? need_q_r : '0;
  assign f_sym   = fifo_q_r[SYM_W+ADDR_W-1:ADDR_W];
  assign f_pos   = fifo_q_r[ADDR_W-1:0];
  assign win_len = LEN_W'(cur_pos_r) - LEN_W'(f_pos) + LEN_W'(1);
  assign op_sym  = op.sym[SYM_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    outst_nxt      = outst_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    tpos_nxt       = tpos_r;
    cur_pos_nxt    = cur_pos_r;
    cur_sym_nxt    = cur_sym_r;
    cur_last_nxt   = cur_last_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    ovf_nxt        = ovf_r;
    clr            = 1'b0;
    member_set     = 1'b0;
    op_pop         = 1'b0;
    need_re        = 1'b0;
    need_we        = 1'b0;
    need_raddr     = cur_sym_r;
    need_waddr     = cur_sym_r;
    need_wdata     = nd + NEED_W'(1);
    fifo_we        = 1'b0;
    fifo_re        = 1'b0;
    res_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop       = 1'b1;
          cur_sym_nxt  = op_sym;
          cur_last_nxt = op.last;
          case (op.kind)
            mwcs_pkg::OP_CLEAR: begin
              clr            = 1'b1;
              outst_nxt      = '0;
              head_nxt       = '0;
              tail_nxt       = '0;
              tpos_nxt       = '0;
              best_start_nxt = '0;
              best_len_nxt   = '0;
              ovf_nxt        = 1'b0;
            end
            mwcs_pkg::OP_PATTERN: begin
              need_re    = 1'b1;
              need_raddr = op_sym;
              state_nxt  = ST_PAT;
            end
            mwcs_pkg::OP_TEXT: begin
              state_nxt = ST_EMIT;
              if (tpos_r >= LEN_W'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                cur_pos_nxt = tpos_r[ADDR_W-1:0];
                tpos_nxt    = tpos_r + LEN_W'(1);
                if (op.in_alpha && member_r[op_sym]) begin
                  fifo_we    = 1'b1;
                  tail_nxt   = tail_r + LEN_W'(1);
                  need_re    = 1'b1;
                  need_raddr = op_sym;
                  state_nxt  = ST_TXT;
                end
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_PAT: begin
        state_nxt = ST_IDLE;
        if (nd[NEED_W-1] || (outst_r != mwcs_pkg::OUTSTANDING_MAX)) begin
          need_we    = 1'b1;
          member_set = 1'b1;
          if (!nd[NEED_W-1]) begin
            outst_nxt = outst_r + OW'(1);
          end
        end
      end
      ST_TXT: begin
        need_we    = 1'b1;
        need_wdata = nd - NEED_W'(1);
        if (!nd[NEED_W-1] && (nd != '0) && (outst_r != '0)) begin
          outst_nxt = outst_r - OW'(1);
        end
        state_nxt = ST_SH;
      end
      ST_SH: begin
        if ((outst_r == '0) && (head_r < tail_r)) begin
          fifo_re   = 1'b1;
          state_nxt = ST_SH_LD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SH_LD: begin
        if ((best_len_r == '0) || (win_len < best_len_r)) begin
          best_len_nxt   = win_len;
          best_start_nxt = f_pos;
        end
        cur_sym_nxt = f_sym;
        need_re     = 1'b1;
        need_raddr  = f_sym;
        state_nxt   = ST_SH_WR;
      end
      ST_SH_WR: begin
        need_we = 1'b1;
        if (!nd[NEED_W-1]) begin
          outst_nxt = outst_r + OW'(1);
        end
        head_nxt  = head_r + LEN_W'(1);
        state_nxt = ST_SH;
      end
      ST_EMIT: begin
        if (!cur_last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_bus.ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (need_we) begin
      need_mem[need_waddr] <= need_wdata;
    end
    if (need_re) begin
      need_q_r <= need_mem[need_raddr];
    end
    if (fifo_we) begin
      fifo_mem[tail_r[ADDR_W-1:0]] <= {op_sym, tpos_r[ADDR_W-1:0]};
    end
    if (fifo_re) begin
      fifo_q_r <= fifo_mem[head_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    cur_pos_r    <= cur_pos_nxt;
    cur_sym_r    <= cur_sym_nxt;
    cur_last_r   <= cur_last_nxt;
    best_start_r <= best_start_nxt;
    if (res_load) begin
      out_found_r <= (best_len_r != '0);
      out_start_r <= (best_len_r != '0) ? mwcs_pkg::WIN_START_W'(best_start_r) : '0;
      out_len_r   <= mwcs_pkg::WIN_LENGTH_W'(best_len_r);
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      outst_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      tpos_r      <= '0;
      best_len_r  <= '0;
      ovf_r       <= 1'b0;
      need_vld_r  <= '0;
      need_vq_r   <= 1'b0;
      member_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      outst_r    <= outst_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      tpos_r     <= tpos_nxt;
      best_len_r <= best_len_nxt;
      ovf_r      <= ovf_nxt;
      if (need_re) begin
        need_vq_r <= need_vld_r[need_raddr];
      end
      if (clr) begin
        need_vld_r <= '0;
        member_r   <= '0;
      end else begin
        if (need_we) begin
          need_vld_r[need_waddr] <= 1'b1;
        end
        if (member_set) begin
          member_r[cur_sym_r] <= 1'b1;
        end
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.found      = out_found_r;
  assign out_bus.win_start  = out_start_r;
  assign out_bus.win_length = out_len_r;
  assign out_bus.overflow   = out_ovf_r;

  `MWCS_NEVER(a_head_past_tail, clk, rst_n, head_r > tail_r)
  `MWCS_NEVER(a_tail_past_pos, clk, rst_n, tail_r > tpos_r)
  `MWCS_ASSERT(a_shrink_only_covered, clk, rst_n, (state_r == ST_SH_LD) |-> (outst_r == '0))
  `MWCS_ASSERT(a_pop_only_idle, clk, rst_n, op_pop |-> (state_r == ST_IDLE))
endmodule

@@ rtl/core/min_window_cover_search_core.sv @@
// Minimum covering window search. Pattern beats build a per-symbol need table;
// text beats of member symbols enter a position fifo and the shortest window
// holding every pattern byte is tracked; a text beat marked last returns one
// result. A clear beat is handled in the idle state; a pattern beat reads and
// then writes its need entry; a text beat passes the idle and emit states, and
// a member symbol adds a need update and a shrink check, plus a fifo load and
// need write-back per head popped while covered (each position is popped at
// most once); a last beat waits for the result register to be taken. A 2-deep
// queue in front lets input beats keep arriving meanwhile.
`timescale 1ns / 1ps
module min_window_cover_search_core #(
  parameter int MAX_LEN  = mwcs_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = mwcs_pkg::ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mwcs_in_if.sink    in_bus,
  mwcs_out_if.source out_bus
);
  logic          op_valid;
  logic          op_pop;
  mwcs_pkg::op_t op;

  mwcs_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  mwcs_back #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .out_bus  (out_bus)
  );
endmodule
